### rtl/core/adsr_pkg.sv
package adsr_pkg;

    localparam int TIME_BITS       = 20;
    localparam int LEVEL_FRAC_BITS = 16;
    localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
    localparam int PHASE_W         = TIME_BITS + 2;
    localparam int PROD_W          = TIME_BITS + LEVEL_W;
    localparam int STEP_CNT_W      = $clog2(LEVEL_W);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W;
    localparam int STAGE_W         = 3;

    localparam logic [LEVEL_W-1:0] ONE_LEVEL = LEVEL_W'(1) << LEVEL_FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK        = 3'd0,
        CFG_DECAY         = 3'd1,
        CFG_SUSTAIN       = 3'd2,
        CFG_SUSTAIN_LEVEL = 3'd3,
        CFG_RELEASE       = 3'd4
    } t_cfg_idx;

    typedef enum logic [STAGE_W-1:0] {
        STG_IDLE     = 3'd0,
        STG_ATTACK   = 3'd1,
        STG_DECAY    = 3'd2,
        STG_SUSTAIN  = 3'd3,
        STG_RELEASE  = 3'd4,
        STG_FINISHED = 3'd5
    } t_stage;

endpackage

### rtl/core/adsr_smul.sv
module adsr_smul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [adsr_pkg::TIME_BITS-1:0] i_mcand,
    input  logic [adsr_pkg::LEVEL_W-1:0]   i_mplier,
    output logic                           o_done,
    output logic [adsr_pkg::PROD_W-1:0]    o_product
);
    import adsr_pkg::*;

    logic [TIME_BITS-1:0]  r_mcand;
    logic [TIME_BITS-1:0]  r_hi;
    logic [LEVEL_W-1:0]    r_lo;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [TIME_BITS:0]    w_sum;

    // one multiplier bit per cycle, lsb first, product shifts right
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_CNT_W'(LEVEL_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= w_sum[TIME_BITS:1];
            r_lo <= {w_sum[0], r_lo[LEVEL_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

endmodule

### rtl/core/adsr_sdiv.sv
module adsr_sdiv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [adsr_pkg::PROD_W-1:0]    i_dividend,
    input  logic [adsr_pkg::TIME_BITS-1:0] i_divisor,
    output logic                           o_done,
    output logic [adsr_pkg::LEVEL_W-1:0]   o_quotient
);
    import adsr_pkg::*;

    logic [TIME_BITS-1:0]  r_div;
    logic [TIME_BITS-1:0]  r_rem;
    logic [LEVEL_W-1:0]    r_q;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [TIME_BITS:0]    w_trial;
    logic [TIME_BITS+1:0]  w_diff;
    logic                  w_ge;

    // quotient is known to fit in LEVEL_W bits, so the upper dividend part
    // starts below the divisor and only LEVEL_W restoring steps are needed
    assign w_trial = {r_rem, r_q[LEVEL_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};
    assign w_ge    = !w_diff[TIME_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_CNT_W'(LEVEL_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // dividend low bits shift out msb first, quotient bits shift in behind
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= i_dividend[PROD_W-1:LEVEL_W];
            r_q   <= i_dividend[LEVEL_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0];
            r_q   <= {r_q[LEVEL_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

### rtl/core/adsr_envelope_generator.sv
// ADSR envelope generator, one transaction on the input channel per sample
// tick, one level/stage transaction out for each. Durations are in ticks and
// the level is unsigned Q1.16 (0x10000 is full scale). A tick is accepted in
// the idle state; S_SUM1 and S_SUM2 form the total duration and S_TRIG decides
// on the trigger. Then come the walk through the stages, one compare-and-
// subtract per cycle, and up to two passes through the 17-step shift-add
// multiplier (retrigger phase, decay or release slope). After that come one
// pass through the 17-step restoring divider and the load of the output
// register. Sustain, finished and idle ticks skip the arithmetic. While the
// output register still holds an unaccepted result, the block waits in the
// output state. The next tick is accepted as soon as a result sits in the
// output register. Configuration writes are always ready and must only be
// issued while no tick is in flight; unknown indexes are ignored.
module adsr_envelope_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_trigger,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [adsr_pkg::LEVEL_W-1:0]    o_level,
    output logic [adsr_pkg::STAGE_W-1:0]    o_stage,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import adsr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM1,
        S_SUM2,
        S_TRIG,
        S_RMUL,
        S_WALK,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [TIME_BITS-1:0]  r_attack;
    logic [TIME_BITS-1:0]  r_decay;
    logic [TIME_BITS-1:0]  r_sustain;
    logic [LEVEL_W-1:0]    r_sustain_level;
    logic [TIME_BITS-1:0]  r_release;

    logic [PHASE_W-1:0]    r_phase;
    logic                  r_idle;
    logic [LEVEL_W-1:0]    r_last;

    logic                  r_trig;
    logic [PHASE_W-1:0]    r_tot;
    logic [PHASE_W-1:0]    r_tmp;
    logic [PHASE_W-1:0]    r_rel;
    t_stage                r_stg;
    logic [LEVEL_W-1:0]    r_res;

    logic                  r_mul_go;
    logic [TIME_BITS-1:0]  r_mul_a;
    logic [LEVEL_W-1:0]    r_mul_b;
    logic                  r_div_go;
    logic [PROD_W-1:0]     r_div_n;
    logic [TIME_BITS-1:0]  r_div_d;

    logic                  r_out_valid;
    logic [LEVEL_W-1:0]    r_level;
    logic [STAGE_W-1:0]    r_stage;

    logic                  w_mul_done;
    logic [PROD_W-1:0]     w_prod;
    logic                  w_div_done;
    logic [LEVEL_W-1:0]    w_quot;
    logic [LEVEL_W-1:0]    w_sl;
    logic [PHASE_W-1:0]    w_rphase;
    logic [PHASE_W-1:0]    w_dur;
    logic                  w_in_stage;
    logic                  w_retrig;

    function automatic logic [PHASE_W-1:0] sat_inc(input logic [PHASE_W-1:0] p,
                                                   input logic [PHASE_W-1:0] tot);
        logic [PHASE_W:0] inc;
        inc = {1'b0, p} + 1'b1;
        return (inc > {1'b0, tot}) ? tot : inc[PHASE_W-1:0];
    endfunction

    adsr_smul u_smul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_go),
        .i_mcand   (r_mul_a),
        .i_mplier  (r_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    adsr_sdiv u_sdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_div_n),
        .i_divisor  (r_div_d),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_sl     = (r_sustain_level > ONE_LEVEL) ? ONE_LEVEL : r_sustain_level;
    assign w_rphase = PHASE_W'(w_prod >> LEVEL_FRAC_BITS);
    assign w_retrig = r_trig && !r_idle && (r_phase < r_tot);

    always_comb begin
        unique case (r_stg)
            STG_ATTACK:  w_dur = PHASE_W'(r_attack);
            STG_DECAY:   w_dur = PHASE_W'(r_decay);
            STG_SUSTAIN: w_dur = PHASE_W'(r_sustain);
            STG_RELEASE: w_dur = PHASE_W'(r_release);
            default:     w_dur = '0;
        endcase
    end

    assign w_in_stage = r_rel < w_dur;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack        <= '0;
            r_decay         <= '0;
            r_sustain       <= '0;
            r_sustain_level <= ONE_LEVEL;
            r_release       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ATTACK:        r_attack        <= i_cfg_data[TIME_BITS-1:0];
                CFG_DECAY:         r_decay         <= i_cfg_data[TIME_BITS-1:0];
                CFG_SUSTAIN:       r_sustain       <= i_cfg_data[TIME_BITS-1:0];
                CFG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_RELEASE:       r_release       <= i_cfg_data[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_idle      <= 1'b1;
            r_last      <= '0;
            r_mul_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
            r_stg       <= STG_IDLE;
        end else begin
            r_mul_go <= ((r_state == S_TRIG) && w_retrig)
                     || ((r_state == S_WALK) && w_in_stage
                         && (r_stg == STG_DECAY || r_stg == STG_RELEASE));
            r_div_go <= ((r_state == S_WALK) && w_in_stage && (r_stg == STG_ATTACK))
                     || ((r_state == S_MUL) && w_mul_done);
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_trig  <= i_trigger;
                        r_state <= S_SUM1;
                    end
                end
                S_SUM1: begin
                    r_tot   <= PHASE_W'(r_attack) + PHASE_W'(r_decay);
                    r_tmp   <= PHASE_W'(r_sustain) + PHASE_W'(r_release);
                    r_state <= S_SUM2;
                end
                S_SUM2: begin
                    r_tot   <= r_tot + r_tmp;
                    r_state <= S_TRIG;
                end
                S_TRIG: begin
                    priority if (w_retrig) begin
                        // retrigger: resume the attack from the present level
                        r_stg    <= STG_ATTACK;
                        r_mul_a  <= r_attack;
                        r_mul_b  <= r_last;
                        r_state  <= S_RMUL;
                    end else if (r_trig) begin
                        r_stg   <= STG_ATTACK;
                        r_idle  <= 1'b0;
                        r_rel   <= '0;
                        r_phase <= sat_inc('0, r_tot);
                        r_state <= S_WALK;
                    end else if (r_idle) begin
                        r_res   <= '0;
                        r_stg   <= STG_IDLE;
                        r_state <= S_OUT;
                    end else begin
                        r_stg   <= STG_ATTACK;
                        r_rel   <= r_phase;
                        r_phase <= sat_inc(r_phase, r_tot);
                        r_state <= S_WALK;
                    end
                end
                S_RMUL: begin
                    if (w_mul_done) begin
                        r_idle  <= 1'b0;
                        r_rel   <= w_rphase;
                        r_phase <= sat_inc(w_rphase, r_tot);
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // one stage per cycle: phase relative to the stage start
                    if (w_in_stage) begin
                        unique case (r_stg)
                            STG_ATTACK: begin
                                r_div_n  <= PROD_W'(r_rel[TIME_BITS-1:0]) << LEVEL_FRAC_BITS;
                                r_div_d  <= r_attack;
                                r_state  <= S_DIV;
                            end
                            STG_DECAY: begin
                                r_mul_a  <= r_rel[TIME_BITS-1:0];
                                r_mul_b  <= ONE_LEVEL - w_sl;
                                r_state  <= S_MUL;
                            end
                            STG_SUSTAIN: begin
                                r_res   <= w_sl;
                                r_state <= S_OUT;
                            end
                            STG_RELEASE: begin
                                r_mul_a  <= r_release - r_rel[TIME_BITS-1:0];
                                r_mul_b  <= w_sl;
                                r_state  <= S_MUL;
                            end
                            default: begin
                                r_res   <= '0;
                                r_stg   <= STG_FINISHED;
                                r_state <= S_OUT;
                            end
                        endcase
                    end else begin
                        r_rel <= r_rel - w_dur;
                        unique case (r_stg)
                            STG_ATTACK:  r_stg <= STG_DECAY;
                            STG_DECAY:   r_stg <= STG_SUSTAIN;
                            STG_SUSTAIN: r_stg <= STG_RELEASE;
                            default: begin
                                r_res   <= '0;
                                r_stg   <= STG_FINISHED;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_div_n  <= w_prod;
                        r_div_d  <= (r_stg == STG_DECAY) ? r_decay : r_release;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res   <= (r_stg == STG_DECAY) ? ONE_LEVEL - w_quot : w_quot;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_level     <= r_res;
                        r_stage     <= r_stg;
                        r_last      <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_level     = r_level;
    assign o_stage     = r_stage;
    assign o_cfg_ready = 1'b1;

    a_finished_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_stage == STG_FINISHED || o_stage == STG_IDLE)) |-> (o_level == '0))
        else $error("idle or finished stage with nonzero level");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_level <= ONE_LEVEL))
        else $error("level above full scale");

    a_sustain_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stage == STG_SUSTAIN) |-> (o_level == w_sl))
        else $error("sustain stage level differs from sustain register");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mul_go && r_div_go))
        else $error("multiplier and divider started together");

endmodule
